### design/d8fd_pkg.sv
`default_nettype none

package d8fd_pkg;

    // Register indexes on the configuration port
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // Register widths and reset values
    localparam int IMG_W_BITS = 9;
    localparam int IMG_H_BITS = 13;
    localparam logic [IMG_W_BITS-1:0] IMG_W_RESET = 9'd256;
    localparam logic [IMG_H_BITS-1:0] IMG_H_RESET = 13'd256;

    // Frame height limits
    localparam logic [IMG_H_BITS-1:0] MIN_SIZE_H = 13'd3;
    localparam logic [IMG_H_BITS-1:0] MAX_HEIGHT = 13'd4096;

    // Width used to clamp the configured width against the line length
    localparam int CMP_W = 13;

    // Result field widths
    localparam int CODE_BITS = 8;
    localparam int ROW_BITS  = 12;
    localparam int COL_BITS  = 8;

    // One-hot code of each direction: E, SE, S, SW, W, NW, N, NE
    localparam logic [CODE_BITS-1:0] DIR_CODE [8] = '{
        8'd1, 8'd2, 8'd4, 8'd8, 8'd16, 8'd32, 8'd64, 8'd128
    };
    localparam logic [CODE_BITS-1:0] CODE_NONE = 8'd0;

    // One result item
    typedef struct packed {
        logic [CODE_BITS-1:0] flow_code;
        logic [ROW_BITS-1:0]  cell_row;
        logic [COL_BITS-1:0]  cell_col;
        logic                 frame_last;
    } result_t;

endpackage

`default_nettype wire

### design/d8_flow_direction.sv
`default_nettype none

// Channel    | Handshake               | Payload
// -----------+-------------------------+--------------------------------------------
// input      | in_valid / in_ready     | elevation
// output     | out_valid / out_ready   | flow_code, cell_row, cell_col, frame_last
// config     | APB psel/penable/pwrite | paddr, pwdata, prdata (pready tied high)
//
// One elevation sample is taken per clock while in_ready is high. The line-buffer
// read is issued at the transfer edge of the sample that completes a window; the
// compare tree and write-back run in the next cycle, when the result is written
// into a two-entry output queue to wait; input stalls when the queued results
// plus the sample in flight fill it and no result leaves in the same cycle.
// Reset clears counters, window and queue and sets both sizes to 256; the line
// buffers are not cleared and are read only after the frame has written them.
module d8_flow_direction #(
    parameter int MAX_WIDTH = 256,
    parameter int ELEV_BITS = 24
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input channel
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [ELEV_BITS-1:0]   elevation,
    // output channel
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [d8fd_pkg::CODE_BITS-1:0]     flow_code,
    output logic [d8fd_pkg::ROW_BITS-1:0]      cell_row,
    output logic [d8fd_pkg::COL_BITS-1:0]      cell_col,
    output logic                               frame_last,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    import d8fd_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = $clog2(MAX_WIDTH + 1);

    // Configuration registers
    logic [IMG_W_BITS-1:0] img_width_reg;
    logic [IMG_H_BITS-1:0] img_height_reg;
    logic                  cfg_write;

    // Raster position of the next sample
    logic [CW-1:0]       col_count_reg;
    logic [ROW_BITS-1:0] row_count_reg;

    // Stage 1: sample whose line-buffer reads are in flight
    logic                        s1_valid_reg;
    logic signed [ELEV_BITS-1:0] s1_elev_reg;
    logic [CW-1:0]               s1_col_reg;
    logic [ROW_BITS-1:0]         s1_row_reg;
    logic                        s1_emit_reg;
    logic                        s1_last_reg;

    // Line buffers and their registered read data
    logic signed [ELEV_BITS-1:0] line_above_mem     [MAX_WIDTH];
    logic signed [ELEV_BITS-1:0] line_two_above_mem [MAX_WIDTH];
    logic signed [ELEV_BITS-1:0] mid_rd_reg;
    logic signed [ELEV_BITS-1:0] top_rd_reg;

    // 3x3 window: 0..2 column c-1 (top, mid, bottom), 3..5 column c-2
    logic signed [ELEV_BITS-1:0] win_reg [6];

    // Output queue
    result_t     queue_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;

    logic                 in_fire;
    logic                 pop;
    logic                 push;
    logic [EW-1:0]        eff_w;
    logic [IMG_H_BITS-1:0] eff_h;
    logic [CMP_W-1:0]     w_ext;
    logic                 last_col;
    logic                 last_row;
    logic [CODE_BITS-1:0] code;
    result_t              result;

    // Compare tree signals
    logic signed [ELEV_BITS-1:0] nb_val [9];
    logic signed [ELEV_BITS-1:0] l1_val [4];
    logic [3:0]                  l1_idx [4];
    logic signed [ELEV_BITS-1:0] l2_val [2];
    logic [3:0]                  l2_idx [2];
    logic signed [ELEV_BITS-1:0] l3_val;
    logic [3:0]                  l3_idx;
    logic [3:0]                  win_idx;

    // APB: always ready, decode on the word address bit
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_comb
    begin
        if (paddr[2] == REG_IMAGE_HEIGHT)
            prdata = 32'(img_height_reg);
        else
            prdata = 32'(img_width_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_width_reg  <= IMG_W_RESET;
            img_height_reg <= IMG_H_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_IMAGE_HEIGHT)
                img_height_reg <= pwdata[IMG_H_BITS-1:0];
            else
                img_width_reg <= pwdata[IMG_W_BITS-1:0];
        end
    end

    // Clamp the frame size to its legal range
    always_comb
    begin
        w_ext = CMP_W'(img_width_reg);
        if (w_ext < CMP_W'(3))
            eff_w = EW'(3);
        else if (w_ext > CMP_W'(MAX_WIDTH))
            eff_w = EW'(MAX_WIDTH);
        else
            eff_w = EW'(w_ext);

        if (img_height_reg < MIN_SIZE_H)
            eff_h = MIN_SIZE_H;
        else if (img_height_reg > MAX_HEIGHT)
            eff_h = MAX_HEIGHT;
        else
            eff_h = img_height_reg;
    end

    assign last_col = (EW'(col_count_reg) + EW'(1)) >= eff_w;
    assign last_row = (IMG_H_BITS'(row_count_reg) + IMG_H_BITS'(1)) >= eff_h;

    // Accept while the queue has room for everything in flight
    assign pop      = out_valid & out_ready;
    assign in_ready = (3'(count_reg) + 3'(s1_valid_reg)) < (3'd2 + 3'(pop));
    assign in_fire  = in_valid & in_ready;

    // Advance the raster position; a config write restarts the frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (cfg_write)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (in_fire)
        begin
            if (last_col)
            begin
                col_count_reg <= '0;
                if (last_row)
                    row_count_reg <= '0;
                else
                    row_count_reg <= row_count_reg + 1'b1;
            end
            else
            begin
                col_count_reg <= col_count_reg + 1'b1;
            end
        end
    end

    // Stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= in_fire;
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_elev_reg <= elevation;
            s1_col_reg  <= col_count_reg;
            s1_row_reg  <= row_count_reg;
            s1_emit_reg <= (row_count_reg >= ROW_BITS'(2)) && (col_count_reg >= CW'(2));
            s1_last_reg <= last_row && last_col;
        end
    end

    // Line buffers: read on transfer, write back from the stage 1 registers
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            line_above_mem[s1_col_reg]     <= s1_elev_reg;
            line_two_above_mem[s1_col_reg] <= mid_rd_reg;
        end
        if (in_fire)
        begin
            mid_rd_reg <= line_above_mem[col_count_reg];
            top_rd_reg <= line_two_above_mem[col_count_reg];
        end
    end

    // Shift the window by one column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else if (s1_valid_reg)
        begin
            win_reg[3] <= win_reg[0];
            win_reg[4] <= win_reg[1];
            win_reg[5] <= win_reg[2];
            win_reg[0] <= top_rd_reg;
            win_reg[1] <= mid_rd_reg;
            win_reg[2] <= s1_elev_reg;
        end
    end

    // Minimum tree: centre first, then E, SE, S, SW, W, NW, N, NE; the earlier
    // entry wins a tie, so the first strictly lower neighbour is kept
    always_comb
    begin
        nb_val[0] = win_reg[1];
        nb_val[1] = mid_rd_reg;
        nb_val[2] = s1_elev_reg;
        nb_val[3] = win_reg[2];
        nb_val[4] = win_reg[5];
        nb_val[5] = win_reg[4];
        nb_val[6] = win_reg[3];
        nb_val[7] = win_reg[0];
        nb_val[8] = top_rd_reg;

        for (int i = 0; i < 4; i++)
        begin
            if (nb_val[2*i+1] < nb_val[2*i])
            begin
                l1_val[i] = nb_val[2*i+1];
                l1_idx[i] = 4'(2*i+1);
            end
            else
            begin
                l1_val[i] = nb_val[2*i];
                l1_idx[i] = 4'(2*i);
            end
        end

        for (int i = 0; i < 2; i++)
        begin
            if (l1_val[2*i+1] < l1_val[2*i])
            begin
                l2_val[i] = l1_val[2*i+1];
                l2_idx[i] = l1_idx[2*i+1];
            end
            else
            begin
                l2_val[i] = l1_val[2*i];
                l2_idx[i] = l1_idx[2*i];
            end
        end

        if (l2_val[1] < l2_val[0])
        begin
            l3_val = l2_val[1];
            l3_idx = l2_idx[1];
        end
        else
        begin
            l3_val = l2_val[0];
            l3_idx = l2_idx[0];
        end

        if (nb_val[8] < l3_val)
            win_idx = 4'd8;
        else
            win_idx = l3_idx;

        if (win_idx == 4'd0)
            code = CODE_NONE;
        else
            code = DIR_CODE[3'(win_idx - 4'd1)];
    end

    // Assemble the result of the finished cell
    always_comb
    begin
        result.flow_code  = code;
        result.cell_row   = s1_row_reg - 1'b1;
        result.cell_col   = COL_BITS'(s1_col_reg - 1'b1);
        result.frame_last = s1_last_reg;
    end

    assign push = s1_valid_reg & s1_emit_reg;

    // Output queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    // Output queue payload
    always_ff @(posedge clk)
    begin
        if (push)
            queue_reg[wr_ptr_reg] <= result;
    end

    assign out_valid  = count_reg != 2'd0;
    assign flow_code  = queue_reg[rd_ptr_reg].flow_code;
    assign cell_row   = queue_reg[rd_ptr_reg].cell_row;
    assign cell_col   = queue_reg[rd_ptr_reg].cell_col;
    assign frame_last = queue_reg[rd_ptr_reg].frame_last;

endmodule

`default_nettype wire

### test/tb_d8_flow_direction.sv
`timescale 1ns / 100ps

module tb_d8_flow_direction;
    import d8fd_pkg::*;

    localparam int LINE_LEN = 256;
    localparam int ELEV_W   = 24;
    localparam logic signed [ELEV_W-1:0] ELEV_MIN = 24'sh800000;
    localparam logic signed [ELEV_W-1:0] ELEV_MAX = 24'sh7FFFFF;

    // Sample count at which the random frames stop
    localparam int unsigned RANDOM_TARGET = 1250;

    // Idle profiles: none, sender idle, receiver stalling, both
    localparam int IDLE_SEND  [4] = '{0, 58, 0, 9};
    localparam int IDLE_STALL [4] = '{0, 0, 58, 9};

    // Pit in the middle of a 5x5 grid: every neighbor of the pit points at it,
    // the pit itself has no lower neighbor, and one corner ties with the pit
    localparam logic signed [ELEV_W-1:0] BOWL_GRID [25] = '{
        ELEV_MIN,   ELEV_MAX,  24'sd0,    -24'sd1,          24'sd42,
        24'sd5,     24'sd100,  -24'sd100, ELEV_MAX,         24'sd3,
        24'sd7,     24'sd1,    ELEV_MIN,  24'sd0,           24'sd2,
        -24'sd7,    ELEV_MAX,  24'sd50,   -24'sd8388607,    24'sd9,
        24'sd0,     24'sd1,    24'sd2,    24'sd3,           ELEV_MAX
    };

    typedef enum int {FILL_FULL, FILL_NARROW, FILL_EXTREME} fill_t;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    logic signed [ELEV_W-1:0]        elevation;
    logic                            out_valid;
    logic                            out_ready;
    logic [CODE_BITS-1:0]            flow_code;
    logic [ROW_BITS-1:0]             cell_row;
    logic [COL_BITS-1:0]             cell_col;
    logic                            frame_last;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [2:0]                      paddr;
    logic [31:0]                     pwdata;
    logic [31:0]                     prdata;
    logic                            pready;

    // Flow-direction state mirrored from the block
    logic signed [ELEV_W-1:0]        prev_row      [LINE_LEN];
    logic signed [ELEV_W-1:0]        prev_prev_row [LINE_LEN];
    logic signed [ELEV_W-1:0]        taps          [6];
    int unsigned                     next_row;
    int unsigned                     next_col;
    logic [IMG_W_BITS-1:0]           width_reg;
    logic [IMG_H_BITS-1:0]           height_reg;
    result_t                         flow_expect_q [$];

    int                              send_idle_pct;
    int                              stall_pct;
    int                              hold_len;
    int                              error_count;
    int unsigned                     samples_sent;
    int unsigned                     codes_checked;
    int unsigned                     size_settings;
    int unsigned                     pits_seen;
    logic [CODE_BITS-1:0]            dirs_seen;

    d8_flow_direction #(
        .MAX_WIDTH (LINE_LEN),
        .ELEV_BITS (ELEV_W)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .elevation  (elevation),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .flow_code  (flow_code),
        .cell_row   (cell_row),
        .cell_col   (cell_col),
        .frame_last (frame_last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #6 clk = ~clk;

    // Clamp the configured sizes the way the block uses them
    function automatic int unsigned cols_in_use();
        int unsigned w;
        w = width_reg;
        if (w < 3) w = 3;
        if (w > LINE_LEN) w = LINE_LEN;
        return w;
    endfunction

    function automatic int unsigned rows_in_use();
        int unsigned h;
        h = height_reg;
        if (h < int'(MIN_SIZE_H)) h = MIN_SIZE_H;
        if (h > int'(MAX_HEIGHT)) h = MAX_HEIGHT;
        return h;
    endfunction

    function automatic void reset_flow_model();
        for (int i = 0; i < LINE_LEN; i++)
        begin
            prev_row[i]      = '0;
            prev_prev_row[i] = '0;
        end
        for (int i = 0; i < 6; i++)
        begin
            taps[i] = '0;
        end
        next_row   = 0;
        next_col   = 0;
        width_reg  = IMG_W_RESET;
        height_reg = IMG_H_RESET;
    endfunction

    // Advance the window by one sample and queue the code of the cell it completes
    function automatic void predict_flow_code(input logic signed [ELEV_W-1:0] e);
        int unsigned                 w;
        int unsigned                 h;
        int unsigned                 r;
        int unsigned                 c;
        logic signed [ELEV_W-1:0]    top;
        logic signed [ELEV_W-1:0]    mid;
        logic signed [ELEV_W-1:0]    lowest;
        logic signed [ELEV_W-1:0]    nb [8];
        logic [CODE_BITS-1:0]        code;
        result_t                     res;
        w   = cols_in_use();
        h   = rows_in_use();
        r   = next_row;
        c   = next_col;
        top = prev_prev_row[c];
        mid = prev_row[c];
        if (r >= 2 && c >= 2)
        begin
            // E, SE, S, SW, W, NW, N, NE
            nb[0]  = mid;
            nb[1]  = e;
            nb[2]  = taps[2];
            nb[3]  = taps[5];
            nb[4]  = taps[4];
            nb[5]  = taps[3];
            nb[6]  = taps[0];
            nb[7]  = top;
            lowest = taps[1];
            code   = CODE_NONE;
            // strictly lower only, so a tie keeps the earlier direction
            for (int d = 0; d < 8; d++)
            begin
                if (nb[d] < lowest)
                begin
                    lowest = nb[d];
                    code   = DIR_CODE[d];
                end
            end
            res.flow_code  = code;
            res.cell_row   = ROW_BITS'(r - 1);
            res.cell_col   = COL_BITS'(c - 1);
            res.frame_last = (r + 1 >= h) && (c + 1 >= w);
            flow_expect_q.insert(flow_expect_q.size(), res);
            dirs_seen |= code;
            if (code == CODE_NONE) pits_seen++;
        end
        // shift the window one column
        taps[3] = taps[0];
        taps[4] = taps[1];
        taps[5] = taps[2];
        taps[0] = top;
        taps[1] = mid;
        taps[2] = e;
        prev_prev_row[c] = mid;
        prev_row[c]      = e;
        // advance the raster position, wrapping at the end of the frame
        if (c + 1 >= w)
        begin
            next_col = 0;
            next_row = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            next_col = c + 1;
        end
    endfunction

    function automatic logic signed [ELEV_W-1:0] rand_elev(input fill_t fill);
        case (fill)
            FILL_NARROW:  return ELEV_W'(int'($urandom_range(4)) - 2);
            FILL_EXTREME:
            begin
                case ($urandom_range(2))
                    0:       return ELEV_MIN;
                    1:       return ELEV_MAX;
                    default: return ELEV_W'($urandom);
                endcase
            end
            default:      return ELEV_W'($urandom);
        endcase
    endfunction

    // Receiver: random stalls, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_len > 0)
        begin
            out_ready <= 1'b0;
            hold_len  <= hold_len - 1;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Compare each output transfer with the oldest expected code
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (flow_expect_q.size() == 0)
            begin
                $error("unexpected result: flow_code %0d row %0d col %0d",
                       flow_code, cell_row, cell_col);
                error_count++;
            end
            else
            begin
                want = flow_expect_q.pop_front();
                if (flow_code !== want.flow_code)
                begin
                    $error("flow_code: expected %0d, actual %0d", want.flow_code, flow_code);
                    error_count++;
                end
                if (cell_row !== want.cell_row)
                begin
                    $error("cell_row: expected %0d, actual %0d", want.cell_row, cell_row);
                    error_count++;
                end
                if (cell_col !== want.cell_col)
                begin
                    $error("cell_col: expected %0d, actual %0d", want.cell_col, cell_col);
                    error_count++;
                end
                if (frame_last !== want.frame_last)
                begin
                    $error("frame_last: expected %0d, actual %0d", want.frame_last,
                           frame_last);
                    error_count++;
                end
                codes_checked++;
            end
        end
    end

    task automatic set_idle(input int mode);
        send_idle_pct = IDLE_SEND[mode];
        stall_pct     = IDLE_STALL[mode];
    endtask

    // Offer one sample, with a random gap first, and hold it until the transfer
    task automatic send_elev(input logic signed [ELEV_W-1:0] value);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid  <= 1'b1;
        elevation <= value;
        do @(posedge clk); while (!in_ready);
        predict_flow_code(value);
        samples_sent++;
    endtask

    task automatic send_block(input int unsigned count, input fill_t fill);
        for (int unsigned i = 0; i < count; i++)
        begin
            send_elev(rand_elev(fill));
        end
    endtask

    // Drop valid, wait for every expected code, then let the pipeline settle
    task automatic wait_drained();
        int guard;
        guard    = 0;
        in_valid <= 1'b0;
        while (flow_expect_q.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
            width_reg = value[IMG_W_BITS-1:0];
        else
            height_reg = value[IMG_H_BITS-1:0];
        // any write restarts the frame
        next_row = 0;
        next_col = 0;
    endtask

    task automatic program_size(input logic [31:0] w_raw, input logic [31:0] h_raw);
        wait_drained();
        write_register(REG_IMAGE_WIDTH, w_raw);
        write_register(REG_IMAGE_HEIGHT, h_raw);
        size_settings++;
    endtask

    // Pit, every direction and a tie, all in one 5x5 frame
    task automatic test_directed();
        program_size(5, 5);
        set_idle(0);
        for (int i = 0; i < 25; i++)
        begin
            send_elev(BOWL_GRID[i]);
        end
    endtask

    // Sizes below the minimum and above the maximum
    task automatic test_size_clamps();
        set_idle(3);
        program_size(0, 8191);
        send_block(90, FILL_FULL);
        program_size(2, 4096);
        send_block(45, FILL_EXTREME);
        program_size(3, 1);
        send_block(18, FILL_NARROW);
    endtask

    // One frame at the full line length
    task automatic test_wide_rows();
        set_idle(3);
        program_size(511, 2);
        send_block(cols_in_use() * rows_in_use(), FILL_FULL);
    endtask

    // Random sizes, whole and cut-off frames, rotating idle profiles
    task automatic test_random_frames();
        int unsigned w_raw;
        int unsigned h_raw;
        int unsigned count;
        int          mode;
        fill_t       fill;
        mode = 0;
        while (samples_sent < RANDOM_TARGET)
        begin
            case ($urandom_range(9))
                0:       w_raw = $urandom_range(2);
                1:       w_raw = $urandom_range(40, 64);
                default: w_raw = $urandom_range(3, 16);
            endcase
            h_raw = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 9);
            program_size(w_raw, h_raw);
            set_idle(mode);
            mode  = (mode + 1) % 4;
            count = cols_in_use() * rows_in_use();
            if ($urandom_range(3) == 0) count = $urandom_range(1, count);
            fill  = fill_t'($urandom_range(2));
            send_block(count, fill);
        end
    endtask

    // Long receiver hold-off while the sender keeps offering samples
    task automatic test_backpressure();
        program_size(8, 10);
        set_idle(0);
        if (hold_len == 0) hold_len <= 300;
        send_block(80, FILL_NARROW);
    endtask

    // Sender pauses after each frame until every code has come out
    task automatic test_paced_frames();
        program_size(4, 4);
        set_idle(2);
        for (int i = 0; i < 4; i++)
        begin
            send_block(16, fill_t'($urandom_range(2)));
            wait_drained();
        end
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        elevation     = '0;
        out_ready     = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_len      = 0;
        error_count   = 0;
        samples_sent  = 0;
        codes_checked = 0;
        size_settings = 0;
        pits_seen     = 0;
        dirs_seen     = '0;
        reset_flow_model();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_size_clamps();
        test_wide_rows();
        test_random_frames();
        test_backpressure();
        test_paced_frames();

        wait_drained();
        if (flow_expect_q.size() != 0)
        begin
            $error("%0d expected flow codes never came out", flow_expect_q.size());
            error_count++;
        end
        $display("Sent %0d elevation samples over %0d size settings, checked %0d flow codes",
                 samples_sent, size_settings, codes_checked);
        $display("Direction codes produced %b, pits or flats %0d", dirs_seen, pits_seen);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Hard stop if the run hangs
    initial
    begin
        #(5_000_000);
        $display("Timeout with %0d flow codes still expected", flow_expect_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
design/d8fd_pkg.sv
design/d8_flow_direction.sv
test/tb_d8_flow_direction.sv
